// ===== hw/rtl/cpu_alu_with_flags_core_macros.svh =====
// Assertion macros shared by the ALU core RTL.
`ifndef CPU_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define CPU_ALU_WITH_FLAGS_CORE_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define CPUALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CPUALU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/cpualu_pkg.sv =====
// Types, operation codes and flag positions for the 8-bit ALU core.
`timescale 1ns / 1ps

package cpualu_pkg;

  localparam int unsigned OpW   = 5;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned FlagW = 4;
  localparam int unsigned BitIdxW = 3;

  // Flag bit positions: Z N H C
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_OR    = 5'd5,
    OP_XOR   = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_CPL   = 5'd10,
    OP_SWAP  = 5'd11,
    OP_RLC   = 5'd12,
    OP_RRC   = 5'd13,
    OP_RL    = 5'd14,
    OP_RR    = 5'd15,
    OP_SLA   = 5'd16,
    OP_SRA   = 5'd17,
    OP_SRL   = 5'd18,
    OP_BIT   = 5'd19,
    OP_SET   = 5'd20,
    OP_RES   = 5'd21,
    OP_ADD16 = 5'd22,
    OP_INC16 = 5'd23,
    OP_DEC16 = 5'd24
  } alu_op_e;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [WordW-1:0]   first_operand;
    logic [WordW-1:0]   second_operand;
    logic [BitIdxW-1:0] bit_index;
    logic [FlagW-1:0]   flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [WordW-1:0] result_value;
    logic [FlagW-1:0] flags_out;
    logic             writes_back;
  } alu_out_t;

endpackage

// ===== hw/rtl/cpualu_exec.sv =====
// Combinational ALU datapath: value, flags and write-back enable for one beat.
`timescale 1ns / 1ps

module cpualu_exec (
  input  cpualu_pkg::alu_in_t  op_i,
  output cpualu_pkg::alu_out_t res_o
);

  logic [cpualu_pkg::ByteW-1:0] a;
  logic [cpualu_pkg::ByteW-1:0] b;
  logic                         cf;
  logic [cpualu_pkg::ByteW-1:0] bmask;
  logic [cpualu_pkg::ByteW:0]   sum9;
  logic [4:0]                   hsum;
  logic [cpualu_pkg::ByteW:0]   dif9;
  logic [4:0]                   hdif;
  logic [cpualu_pkg::WordW:0]   sum17;
  logic [12:0]                  hsum13;

  assign a     = op_i.first_operand[cpualu_pkg::ByteW-1:0];
  assign b     = op_i.second_operand[cpualu_pkg::ByteW-1:0];
  assign cf    = op_i.flags_in[cpualu_pkg::FlagC];
  assign bmask = 8'h01 << op_i.bit_index;

  // adc/sbc take carry in; add/sub/cp do not
  logic cin_add;
  logic cin_sub;
  assign cin_add = (op_i.operation == cpualu_pkg::OP_ADC) ? cf : 1'b0;
  assign cin_sub = (op_i.operation == cpualu_pkg::OP_SBC) ? cf : 1'b0;

  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
  assign hsum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
  assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
  assign hdif   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};
  assign sum17  = {1'b0, op_i.first_operand} + {1'b0, op_i.second_operand};
  assign hsum13 = {1'b0, op_i.first_operand[11:0]} + {1'b0, op_i.second_operand[11:0]};

  always_comb begin
    logic [cpualu_pkg::ByteW-1:0] r8;
    logic [cpualu_pkg::WordW-1:0] r16;
    logic                         wide;
    logic [cpualu_pkg::FlagW-1:0] nf;
    logic                         wb;
    logic                         cnew;
    logic                         zsel;

    r8   = '0;
    r16  = '0;
    wide = 1'b0;
    nf   = op_i.flags_in;
    wb   = 1'b1;
    cnew = 1'b0;
    zsel = 1'b0;

    unique case (cpualu_pkg::alu_op_e'(op_i.operation))
      cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
        r8 = sum9[7:0];
        nf = {1'b0, 1'b0, hsum[4], sum9[8]};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC: begin
        r8 = dif9[7:0];
        nf = {1'b0, 1'b1, hdif[4], dif9[8]};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_CP: begin
        // flags from the difference, value is the untouched accumulator
        r8 = a;
        wb = 1'b0;
        nf = {(dif9[7:0] == 8'h00), 1'b1, hdif[4], dif9[8]};
      end
      cpualu_pkg::OP_AND: begin
        r8 = a & b;
        nf = 4'b0010;
        zsel = 1'b1;
      end
      cpualu_pkg::OP_OR: begin
        r8 = a | b;
        nf = '0;
        zsel = 1'b1;
      end
      cpualu_pkg::OP_XOR: begin
        r8 = a ^ b;
        nf = '0;
        zsel = 1'b1;
      end
      cpualu_pkg::OP_INC: begin
        r8 = a + 8'd1;
        nf = {1'b0, 1'b0, (r8[3:0] == 4'h0), cf};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_DEC: begin
        r8 = a - 8'd1;
        nf = {1'b0, 1'b1, (r8[3:0] == 4'hF), cf};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_CPL: begin
        r8 = ~a;
        nf = {op_i.flags_in[cpualu_pkg::FlagZ], 1'b1, 1'b1, cf};
      end
      cpualu_pkg::OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        nf = '0;
        zsel = 1'b1;
      end
      cpualu_pkg::OP_RLC: begin
        r8 = {a[6:0], a[7]};
        cnew = a[7];
        nf = {3'b000, cnew};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_RRC: begin
        r8 = {a[0], a[7:1]};
        cnew = a[0];
        nf = {3'b000, cnew};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_RL: begin
        r8 = {a[6:0], cf};
        cnew = a[7];
        nf = {3'b000, cnew};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_RR: begin
        r8 = {cf, a[7:1]};
        cnew = a[0];
        nf = {3'b000, cnew};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        cnew = a[7];
        nf = {3'b000, cnew};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_SRA: begin
        r8 = {a[7], a[7:1]};
        cnew = a[0];
        nf = {3'b000, cnew};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        cnew = a[0];
        nf = {3'b000, cnew};
        zsel = 1'b1;
      end
      cpualu_pkg::OP_BIT: begin
        r8 = a;
        wb = 1'b0;
        nf = {((a & bmask) == 8'h00), 1'b0, 1'b1, cf};
      end
      cpualu_pkg::OP_SET: begin
        r8 = a | bmask;
      end
      cpualu_pkg::OP_RES: begin
        r8 = a & ~bmask;
      end
      cpualu_pkg::OP_ADD16: begin
        wide = 1'b1;
        r16 = sum17[15:0];
        nf = {op_i.flags_in[cpualu_pkg::FlagZ], 1'b0, hsum13[12], sum17[16]};
      end
      cpualu_pkg::OP_INC16: begin
        wide = 1'b1;
        r16 = op_i.first_operand + 16'd1;
      end
      cpualu_pkg::OP_DEC16: begin
        wide = 1'b1;
        r16 = op_i.first_operand - 16'd1;
      end
      default: begin
        // undefined opcodes: zero value, flags pass, no write-back
        wb = 1'b0;
      end
    endcase

    if (zsel) begin
      nf[cpualu_pkg::FlagZ] = (r8 == 8'h00);
    end

    res_o.result_value = wide ? r16 : {8'd0, r8};
    res_o.flags_out    = nf;
    res_o.writes_back  = wb;
  end

endmodule

// ===== hw/rtl/cpu_alu_with_flags_core.sv =====
// Top level of the 8-bit ALU core: input register, datapath, result register.
//
//   beat     | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------
//   request  | in  | in_valid_i / in_stall_o | in_data_i  (cpualu_pkg::alu_in_t)
//   result   | out | out_valid_o / out_stall_i | out_data_o (cpualu_pkg::alu_out_t)
//
// A request beat is captured in the input register, then passes through the
// datapath into the result register, which raises result valid. Throughput is
// one beat per cycle while the result is not stalled, set by the single
// register-to-register pass through the datapath. A held result does not
// block intake while the input register is free, so one extra beat is
// absorbed. in_stall_o rises only when both registers are full and the result
// is stalled. Reset clears both valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "cpu_alu_with_flags_core_macros.svh"

module cpu_alu_with_flags_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cpualu_pkg::alu_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cpualu_pkg::alu_out_t out_data_o
);

  // input register
  logic                 s1_valid_d, s1_valid_q;
  cpualu_pkg::alu_in_t  s1_q;
  // result register
  logic                 out_valid_d, out_valid_q;
  cpualu_pkg::alu_out_t out_q;

  cpualu_pkg::alu_out_t exec_res;
  logic                 in_take;
  logic                 s1_adv;
  logic                 out_drain;

  cpualu_exec u_exec (
    .op_i  (s1_q),
    .res_o (exec_res)
  );

  // input stage moves on whenever the result register is empty or draining
  assign out_drain  = out_valid_q && !out_stall_i;
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_drain) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= exec_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // accepted beat is always captured in the input register
  `CPUALU_ASSERT(a_take_lands, (in_valid_i && !in_stall_o) |=> s1_valid_q, "accepted beat lost")
  // an unstalled input register always hands its beat to the result register
  `CPUALU_ASSERT(a_adv_lands, (s1_valid_q && !in_stall_o) |=> out_valid_o, "beat not advanced")
  // undefined opcodes never write back and give a zero value
  `CPUALU_ASSERT(a_bad_op, (s1_valid_q && (s1_q.operation > cpualu_pkg::OP_DEC16)) |-> (!exec_res.writes_back && (exec_res.result_value == '0)), "undefined opcode writes")
  // once an edge has seen reset, nothing is presented at the next one
  `CPUALU_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> (!out_valid_o && !in_stall_o), "busy in reset")

endmodule

// ===== sim/cpu_alu_with_flags_core_test.sv =====
// Self-checking testbench for the flag-producing ALU core: predicts every result and compares it.
`timescale 1ns / 1ps

module cpu_alu_with_flags_core_test;

  localparam int unsigned OpW     = cpualu_pkg::OpW;
  localparam int unsigned WordW   = cpualu_pkg::WordW;
  localparam int unsigned FlagW   = cpualu_pkg::FlagW;
  localparam int unsigned BitIdxW = cpualu_pkg::BitIdxW;

  // Operation codes the core leaves unassigned; they must come back as a
  // no-op with flags passed through.
  localparam logic [OpW-1:0] OP_UNUSED_LO = OpW'(cpualu_pkg::OP_DEC16 + 1);
  localparam logic [OpW-1:0] OP_UNUSED_HI = '1;

  // Random stretch with no idling on either side, counted in beats.
  localparam int unsigned QuietFrom = 500;
  localparam int unsigned QuietTo   = 700;
  localparam int unsigned RandomReqs = 1100;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cpualu_pkg::alu_in_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cpualu_pkg::alu_out_t out_data;

  cpualu_pkg::alu_in_t  pending_reqs[$];      // requests not yet presented to the core
  cpualu_pkg::alu_out_t predicted_results[$]; // one entry per accepted request, oldest first
  cpualu_pkg::alu_out_t want;
  int unsigned sent_count = 0;
  int unsigned recv_count = 0;
  int unsigned mismatch_count = 0;

  cpu_alu_with_flags_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Idle is chosen with a probability of 33 percent, except inside the quiet window.
  function automatic bit idle_now(input int unsigned beats);
    return ($urandom_range(99) < 33) && !(beats >= QuietFrom && beats < QuietTo);
  endfunction

  function automatic cpualu_pkg::alu_in_t make_req(input logic [OpW-1:0] op,
                                                   input logic [WordW-1:0] a,
                                                   input logic [WordW-1:0] b,
                                                   input logic [BitIdxW-1:0] bi,
                                                   input logic [FlagW-1:0] f);
    cpualu_pkg::alu_in_t req;
    req.operation      = op;
    req.first_operand  = a;
    req.second_operand = b;
    req.bit_index      = bi;
    req.flags_in       = f;
    return req;
  endfunction

  // Operand mix: boundaries of the byte and nibble carries plus plain random,
  // upper byte random in most picks so byte ops prove they ignore it.
  function automatic logic [WordW-1:0] pick_operand();
    logic [7:0] hi;
    hi = 8'($urandom);
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {hi, 8'h00};
      3: return {hi, 8'hFF};
      4: return {hi, 8'h0F};
      5: return {hi, 8'h80};
      6: return {4'($urandom), 12'hFFF};
      default: return 16'($urandom);
    endcase
  endfunction

  // Expected result of one request.
  function automatic cpualu_pkg::alu_out_t predict_alu(input cpualu_pkg::alu_in_t req);
    logic [7:0]  a, b, r8;
    logic [15:0] a16, b16;
    logic        cin, c;
    logic [3:0]  f;
    logic [8:0]  wide9;
    logic [4:0]  nib5;
    logic [16:0] wide17;
    logic [12:0] low13;
    cpualu_pkg::alu_out_t o;
    a   = req.first_operand[7:0];
    b   = req.second_operand[7:0];
    a16 = req.first_operand;
    b16 = req.second_operand;
    f   = req.flags_in;
    cin = f[cpualu_pkg::FlagC];
    o.flags_out   = f;
    o.writes_back = 1'b1;
    o.result_value = '0;
    r8 = '0;
    case (req.operation)
      cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
        c     = (req.operation == cpualu_pkg::OP_ADC) ? cin : 1'b0;
        wide9 = {1'b0, a} + {1'b0, b} + {8'd0, c};
        nib5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
        r8    = wide9[7:0];
        o.flags_out = {r8 == 8'h00, 1'b0, nib5[4], wide9[8]};
      end
      cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP: begin
        c     = (req.operation == cpualu_pkg::OP_SBC) ? cin : 1'b0;
        wide9 = {1'b0, a} - {1'b0, b} - {8'd0, c};
        nib5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c};
        r8    = wide9[7:0];
        o.flags_out = {r8 == 8'h00, 1'b1, nib5[4], wide9[8]};
        // compare leaves the accumulator alone
        if (req.operation == cpualu_pkg::OP_CP) begin
          r8 = a;
          o.writes_back = 1'b0;
        end
      end
      cpualu_pkg::OP_AND: begin
        r8 = a & b;
        o.flags_out = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      cpualu_pkg::OP_OR: begin
        r8 = a | b;
        o.flags_out = {r8 == 8'h00, 3'b000};
      end
      cpualu_pkg::OP_XOR: begin
        r8 = a ^ b;
        o.flags_out = {r8 == 8'h00, 3'b000};
      end
      cpualu_pkg::OP_INC: begin
        r8 = a + 8'd1;
        o.flags_out = {r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, f[cpualu_pkg::FlagC]};
      end
      cpualu_pkg::OP_DEC: begin
        r8 = a - 8'd1;
        o.flags_out = {r8 == 8'h00, 1'b1, r8[3:0] == 4'hF, f[cpualu_pkg::FlagC]};
      end
      cpualu_pkg::OP_CPL: begin
        r8 = ~a;
        o.flags_out = {f[cpualu_pkg::FlagZ], 1'b1, 1'b1, f[cpualu_pkg::FlagC]};
      end
      cpualu_pkg::OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        o.flags_out = {r8 == 8'h00, 3'b000};
      end
      cpualu_pkg::OP_RLC: begin
        r8 = {a[6:0], a[7]};
        o.flags_out = {r8 == 8'h00, 2'b00, a[7]};
      end
      cpualu_pkg::OP_RRC: begin
        r8 = {a[0], a[7:1]};
        o.flags_out = {r8 == 8'h00, 2'b00, a[0]};
      end
      cpualu_pkg::OP_RL: begin
        r8 = {a[6:0], cin};
        o.flags_out = {r8 == 8'h00, 2'b00, a[7]};
      end
      cpualu_pkg::OP_RR: begin
        r8 = {cin, a[7:1]};
        o.flags_out = {r8 == 8'h00, 2'b00, a[0]};
      end
      cpualu_pkg::OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        o.flags_out = {r8 == 8'h00, 2'b00, a[7]};
      end
      cpualu_pkg::OP_SRA: begin
        r8 = {a[7], a[7:1]};
        o.flags_out = {r8 == 8'h00, 2'b00, a[0]};
      end
      cpualu_pkg::OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        o.flags_out = {r8 == 8'h00, 2'b00, a[0]};
      end
      cpualu_pkg::OP_BIT: begin
        r8 = a;
        o.writes_back = 1'b0;
        o.flags_out = {~a[req.bit_index], 1'b0, 1'b1, f[cpualu_pkg::FlagC]};
      end
      cpualu_pkg::OP_SET: r8 = a | (8'd1 << req.bit_index);
      cpualu_pkg::OP_RES: r8 = a & ~(8'd1 << req.bit_index);
      default: ;
    endcase
    o.result_value = {8'h00, r8};
    // word ops and unused codes override the byte result
    case (req.operation)
      cpualu_pkg::OP_ADD16: begin
        wide17 = {1'b0, a16} + {1'b0, b16};
        low13  = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        o.result_value = wide17[15:0];
        o.flags_out = {f[cpualu_pkg::FlagZ], 1'b0, low13[12], wide17[16]};
      end
      cpualu_pkg::OP_INC16: o.result_value = a16 + 16'd1;
      cpualu_pkg::OP_DEC16: o.result_value = a16 - 16'd1;
      default: begin
        if (req.operation > cpualu_pkg::OP_DEC16) begin
          o.result_value = '0;
          o.flags_out    = f;
          o.writes_back  = 1'b0;
        end
      end
    endcase
    return o;
  endfunction

  // Request driver. A beat moves on an edge with valid high and stall low; the
  // payload only changes once the current beat has gone, so nothing shifts
  // under a stall. Each accepted beat queues its prediction here.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(predict_alu(in_data));
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && !idle_now(sent_count)) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Stall is free to move each cycle; a beat is checked on
  // the edge it is taken, against the oldest prediction.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        recv_count++;
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing predicted: %h", out_data));
        end else begin
          want = predicted_results.pop_front();
          if (out_data.result_value !== want.result_value)
            report_mismatch($sformatf("beat %0d value %h, predicted %h", recv_count,
                                      out_data.result_value, want.result_value));
          if (out_data.flags_out !== want.flags_out)
            report_mismatch($sformatf("beat %0d flags %b, predicted %b", recv_count,
                                      out_data.flags_out, want.flags_out));
          if (out_data.writes_back !== want.writes_back)
            report_mismatch($sformatf("beat %0d write-back %b, predicted %b", recv_count,
                                      out_data.writes_back, want.writes_back));
        end
      end
      out_stall <= idle_now(recv_count);
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [OpW-1:0] op;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed: every operation once; even codes get FF0F, FF01 and all flags
    // low, odd codes 0000, FFFF and all flags high; byte ops must drop upper bytes.
    for (int code = cpualu_pkg::OP_ADD; code <= cpualu_pkg::OP_DEC16; code++) begin
      op = OpW'(code);
      if (code % 2 == 0)
        pending_reqs.push_back(make_req(op, 16'hFF0F, 16'hFF01, '0, 4'h0));
      else
        pending_reqs.push_back(make_req(op, 16'h0000, 16'hFFFF, '1, 4'hF));
    end
    // Corner cases: byte add wrapping to zero, equal compare, bit test of a
    // clear bit, word add and increment overflowing, word decrement from zero,
    // and both ends of the unused code range.
    pending_reqs.push_back(make_req(cpualu_pkg::OP_ADD, 16'h00FF, 16'h0001, '0, 4'h0));
    pending_reqs.push_back(make_req(cpualu_pkg::OP_CP, 16'h1242, 16'hAB42, '0, 4'h0));
    pending_reqs.push_back(make_req(cpualu_pkg::OP_BIT, 16'hFF7F, 16'h0000, 3'd7, 4'h0));
    pending_reqs.push_back(make_req(cpualu_pkg::OP_ADD16, 16'hFFFF, 16'h0001, '0, 4'h8));
    pending_reqs.push_back(make_req(cpualu_pkg::OP_INC16, 16'hFFFF, 16'h0000, '0, 4'h5));
    pending_reqs.push_back(make_req(cpualu_pkg::OP_DEC16, 16'h0000, 16'h0000, '0, 4'hA));
    pending_reqs.push_back(make_req(OP_UNUSED_LO, 16'hFFFF, 16'hFFFF, '1, 4'h9));
    pending_reqs.push_back(make_req(OP_UNUSED_HI, 16'h1234, 16'h5678, '0, 4'h6));

    // Hold off until the directed set has fully drained through the core.
    while (pending_reqs.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk_i);

    // Random: mostly defined operations, a few unused codes.
    for (int n = 0; n < RandomReqs; n++) begin
      if ($urandom_range(15) == 0)
        op = OpW'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      else
        op = OpW'($urandom_range(cpualu_pkg::OP_DEC16, cpualu_pkg::OP_ADD));
      pending_reqs.push_back(make_req(op, pick_operand(), pick_operand(),
                                      BitIdxW'($urandom), FlagW'($urandom)));
    end

    while (pending_reqs.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk_i);
    // two-stage core: waiting on after the drain catches any stray extra beat
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("** cpu_alu_with_flags_core: PASSED **");
    end else begin
      $display("** cpu_alu_with_flags_core: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("** cpu_alu_with_flags_core: FAILED **");
    $finish;
  end

endmodule

// ===== cpu_alu_with_flags_core.f =====
+incdir+hw/rtl
hw/rtl/cpualu_pkg.sv
hw/rtl/cpualu_exec.sv
hw/rtl/cpu_alu_with_flags_core.sv
sim/cpu_alu_with_flags_core_test.sv
